@@ sv/spms_pkg.sv @@
// spms_pkg: types, constants and helper functions for the spectral power unit.
// No dependencies.
`timescale 1ns / 1ps
package spms_pkg;

  localparam int PTS        = 64;
  localparam int PTS_LOG    = $clog2(PTS);
  localparam int MAX_FRAMES = 1024;
  localparam int FT_W       = 11;
  localparam int FI_W       = 10;
  localparam int BIN_W      = 6;
  localparam int SMP_W      = 16;
  localparam int DAT_W      = 32;
  localparam int MEAN_W     = 32;
  localparam int SPR_W      = 48;
  localparam int DIV_STEPS  = SPR_W;
  localparam int SQRT_STEPS = 32;
  localparam int ST_W       = $clog2(PTS_LOG + 1);
  localparam logic [FT_W-1:0] FT_RESET = FT_W'(16);

  typedef enum logic [4:0] {
    S_IDLE, S_LD_RD, S_LD_WR,
    S_BF_RB, S_BF_RA, S_BF_M1, S_BF_M2, S_BF_M3, S_BF_M4, S_BF_M5, S_BF_WA, S_BF_WB,
    S_P_RD, S_P_M1, S_P_M2, S_P_M3, S_P_M4, S_P_M5,
    S_DIV_M, S_DIV_S, S_SQRT, S_OUT
  } state_t;

  function automatic logic signed [17:0] qcos(input logic [4:0] k);
    logic signed [17:0] v;
    case (k)
      5'd0:  v = 18'sd32768;
      5'd1:  v = 18'sd32610;
      5'd2:  v = 18'sd32138;
      5'd3:  v = 18'sd31357;
      5'd4:  v = 18'sd30274;
      5'd5:  v = 18'sd28899;
      5'd6:  v = 18'sd27246;
      5'd7:  v = 18'sd25330;
      5'd8:  v = 18'sd23170;
      5'd9:  v = 18'sd20788;
      5'd10: v = 18'sd18205;
      5'd11: v = 18'sd15447;
      5'd12: v = 18'sd12540;
      5'd13: v = 18'sd9512;
      5'd14: v = 18'sd6393;
      5'd15: v = 18'sd3212;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [17:0] cos64(input logic [4:0] m);
    logic [4:0] k;
    k = 5'd0 - m;
    return (m <= 5'd16) ? qcos(m) : -qcos(k);
  endfunction

  function automatic logic signed [17:0] sin64(input logic [4:0] m);
    logic [4:0] k1;
    logic [4:0] k2;
    k1 = 5'd16 - m;
    k2 = m - 5'd16;
    return (m <= 5'd16) ? qcos(k1) : qcos(k2);
  endfunction

  function automatic logic [PTS_LOG-1:0] bitrev(input logic [PTS_LOG-1:0] x);
    logic [PTS_LOG-1:0] r;
    for (int i = 0; i < PTS_LOG; i++) r[i] = x[PTS_LOG-1-i];
    return r;
  endfunction

  function automatic logic signed [DAT_W-1:0] rnd15(input logic signed [65:0] x);
    logic signed [65:0] t;
    t = (x + 66'sd16384) >>> 15;
    return t[DAT_W-1:0];
  endfunction

endpackage

@@ sv/spms_ram.sv @@
// spms_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module spms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ sv/spectral_power_mean_spread_unit.sv @@
// Spectral power mean/spread unit: buffers a frame of Q1.15 samples, runs an in-place radix-2
// FFT on a shared multiplier, then updates per-bin mean and spread accumulators and emits one
// beat per bin. Depends on spms_pkg and spms_ram.
`timescale 1ns / 1ps
// A sample beat is taken every cycle while collecting a frame. The beat that completes a frame
// starts processing, during which in_stall is high: bit-reversed loading, 192 butterflies
// on one multiplier, then per bin the power and accumulator update, a shared divider run twice,
// a square root and an output beat that waits out any output stall. Accumulators clear via
// per-bin valid bits after frames_total frames (clamped to 1..MAX_FRAMES).
module spectral_power_mean_spread_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [spms_pkg::FT_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [spms_pkg::SMP_W-1:0] sample,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [spms_pkg::BIN_W-1:0]  bin_index,
  output logic [spms_pkg::FI_W-1:0]   frame_index,
  output logic [spms_pkg::MEAN_W-1:0] mean_power,
  output logic [31:0]                 spread,
  output logic                        last_of_frame
);
  import spms_pkg::*;

  state_t state, state_next;

  logic [FT_W-1:0]    frames_total;
  logic [FT_W-1:0]    divisor;
  logic [PTS_LOG-1:0] pos;
  logic [FI_W-1:0]    frame_count;
  logic [PTS_LOG-1:0] idx;
  logic [ST_W-1:0]    stg;
  logic [5:0]         it;
  logic [PTS-1:0]     acc_vld;

  logic signed [DAT_W-1:0] br, bi, ar, ai, tr, ti;
  logic signed [65:0] prod, acc;
  logic signed [32:0] mul_a, mul_b;
  logic [MEAN_W-1:0] m_new, mq;
  logic [31:0]       d;
  logic [MEAN_W-1:0] mold;
  logic [SPR_W-1:0]  sold;
  logic [SPR_W-1:0]  sp_new;
  logic [SPR_W-1:0]  div_num;
  logic [FT_W-1:0]   div_rem;
  logic [63:0]       sq_v;
  logic [33:0]       sq_rem;
  logic [31:0]       sq_root;

  // frame buffer
  logic               fb_we;
  logic [SMP_W-1:0]   fb_rdata;
  // FFT workspace
  logic               ws_we;
  logic [PTS_LOG-1:0] ws_waddr, ws_raddr;
  logic [2*DAT_W-1:0] ws_wdata, ws_rdata;
  // accumulators
  logic               acc_we;
  logic [MEAN_W-1:0]  mean_rdata;
  logic [SPR_W-1:0]   spr_rdata;

  // butterfly addressing
  logic [PTS_LOG-1:0] half, kk, a_addr, b_addr;
  logic [4:0]         tw;
  logic signed [17:0] tc, ts;
  logic [PTS_LOG-1:0] bf_last;

  always_comb begin
    half   = PTS_LOG'(1) << stg;
    kk     = idx & (half - PTS_LOG'(1));
    a_addr = ((idx >> stg) << (stg + ST_W'(1))) | kk;
    b_addr = a_addr | half;
    tw     = 5'((kk << (ST_W'(5) - stg)));
    tc     = cos64(tw);
    ts     = sin64(tw);
    bf_last = PTS_LOG'(PTS / 2 - 1);
  end

  assign divisor = (frames_total == '0) ? FT_W'(1) :
                   (frames_total > FT_W'(MAX_FRAMES)) ? FT_W'(MAX_FRAMES) : frames_total;

  spms_ram #(.WIDTH(SMP_W), .DEPTH(PTS)) u_fb (
    .clk(clk), .we(fb_we), .waddr(pos), .wdata(sample),
    .raddr(bitrev(idx)), .rdata(fb_rdata)
  );
  spms_ram #(.WIDTH(2*DAT_W), .DEPTH(PTS)) u_ws (
    .clk(clk), .we(ws_we), .waddr(ws_waddr), .wdata(ws_wdata),
    .raddr(ws_raddr), .rdata(ws_rdata)
  );
  spms_ram #(.WIDTH(MEAN_W), .DEPTH(PTS)) u_mean (
    .clk(clk), .we(acc_we), .waddr(idx), .wdata(m_new),
    .raddr(idx), .rdata(mean_rdata)
  );
  spms_ram #(.WIDTH(SPR_W), .DEPTH(PTS)) u_spr (
    .clk(clk), .we(acc_we), .waddr(idx), .wdata(sp_new),
    .raddr(idx), .rdata(spr_rdata)
  );

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign fb_we     = (state == S_IDLE) && in_valid;
  assign acc_we    = (state == S_P_M5);

  // sp_new computed combinationally from the d*d product in S_P_M5
  logic [41:0] sq_term;
  logic [48:0] sp_sum;
  always_comb begin
    sq_term = prod[63:22];
    sp_sum  = {1'b0, sold} + 49'(sq_term);
    sp_new  = sp_sum[48] ? {SPR_W{1'b1}} : sp_sum[SPR_W-1:0];
  end

  // shared multiplier operand select and workspace port control
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    ws_we    = 1'b0;
    ws_waddr = idx;
    ws_wdata = '0;
    ws_raddr = idx;
    case (state)
      S_LD_WR: begin
        ws_we    = 1'b1;
        ws_wdata = {DAT_W'(signed'(fb_rdata)), DAT_W'(0)};
      end
      S_BF_RB: ws_raddr = b_addr;
      S_BF_RA: ws_raddr = a_addr;
      S_BF_M1: begin mul_a = 33'(br); mul_b = 33'(tc); end
      S_BF_M2: begin mul_a = 33'(bi); mul_b = 33'(ts); end
      S_BF_M3: begin mul_a = 33'(bi); mul_b = 33'(tc); end
      S_BF_M4: begin mul_a = 33'(br); mul_b = 33'(ts); end
      S_BF_WA: begin
        ws_we    = 1'b1;
        ws_waddr = a_addr;
        ws_wdata = {ar + tr, ai + ti};
      end
      S_BF_WB: begin
        ws_we    = 1'b1;
        ws_waddr = b_addr;
        ws_wdata = {ar - tr, ai - ti};
      end
      S_P_M1: begin
        mul_a = 33'(signed'(ws_rdata[2*DAT_W-1:DAT_W]));
        mul_b = 33'(signed'(ws_rdata[2*DAT_W-1:DAT_W]));
      end
      S_P_M2: begin mul_a = 33'(bi); mul_b = 33'(bi); end
      S_P_M4: begin mul_a = {1'b0, d}; mul_b = {1'b0, d}; end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid && pos == PTS_LOG'(PTS - 1)) state_next = S_LD_RD;
      S_LD_RD: state_next = S_LD_WR;
      S_LD_WR: state_next = (idx == PTS_LOG'(PTS - 1)) ? S_BF_RB : S_LD_RD;
      S_BF_RB: state_next = S_BF_RA;
      S_BF_RA: state_next = S_BF_M1;
      S_BF_M1: state_next = S_BF_M2;
      S_BF_M2: state_next = S_BF_M3;
      S_BF_M3: state_next = S_BF_M4;
      S_BF_M4: state_next = S_BF_M5;
      S_BF_M5: state_next = S_BF_WA;
      S_BF_WA: state_next = S_BF_WB;
      S_BF_WB: begin
        if (idx == bf_last && stg == ST_W'(PTS_LOG - 1)) state_next = S_P_RD;
        else state_next = S_BF_RB;
      end
      S_P_RD:  state_next = S_P_M1;
      S_P_M1:  state_next = S_P_M2;
      S_P_M2:  state_next = S_P_M3;
      S_P_M3:  state_next = S_P_M4;
      S_P_M4:  state_next = S_P_M5;
      S_P_M5:  state_next = S_DIV_M;
      S_DIV_M: if (it == 6'(DIV_STEPS - 1)) state_next = S_DIV_S;
      S_DIV_S: if (it == 6'(DIV_STEPS - 1)) state_next = S_SQRT;
      S_SQRT:  if (it == 6'(SQRT_STEPS - 1)) state_next = S_OUT;
      S_OUT: begin
        if (!out_stall) state_next = (idx == PTS_LOG'(PTS - 1)) ? S_IDLE : S_P_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // divider and square root step logic
  logic [FT_W:0]  dv_trial;
  logic [FT_W:0]  dv_diff;
  logic           dv_ge;
  logic [33:0]    sr_rem2, sr_trial;
  logic           sr_ge;
  logic [SPR_W+1:0] p_full;
  logic [44:0]    m_sum;
  logic [MEAN_W-1:0] m_sat;
  always_comb begin
    dv_trial = {div_rem, div_num[SPR_W-1]};
    dv_ge    = dv_trial >= {1'b0, divisor};
    dv_diff  = dv_trial - {1'b0, divisor};
    sr_rem2  = {sq_rem[31:0], sq_v[63:62]};
    sr_trial = {sq_root, 2'b01};
    sr_ge    = sr_rem2 >= sr_trial;
    p_full   = 50'(acc + prod) >> 14;
    m_sum    = 45'(mold) + 45'(p_full >> PTS_LOG);
    m_sat    = (m_sum[44:32] != '0) ? {MEAN_W{1'b1}} : m_sum[MEAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_total <= FT_RESET;
      pos          <= '0;
      frame_count  <= '0;
      idx          <= '0;
      stg          <= '0;
      it           <= '0;
      acc_vld      <= '0;
    end else begin
      if (cfg_wr_en) frames_total <= cfg_wr_data;
      prod <= mul_a * mul_b;
      case (state)
        S_IDLE: begin
          idx <= '0;
          stg <= '0;
          if (in_valid) pos <= pos + PTS_LOG'(1);
        end
        S_LD_WR: idx <= idx + PTS_LOG'(1);
        S_BF_RA: begin
          br <= signed'(ws_rdata[2*DAT_W-1:DAT_W]);
          bi <= signed'(ws_rdata[DAT_W-1:0]);
        end
        S_BF_M1: begin
          ar <= signed'(ws_rdata[2*DAT_W-1:DAT_W]);
          ai <= signed'(ws_rdata[DAT_W-1:0]);
        end
        S_BF_M2: acc <= prod;
        S_BF_M3: tr <= rnd15(acc + prod);
        S_BF_M4: acc <= prod;
        S_BF_M5: ti <= rnd15(acc - prod);
        S_BF_WB: begin
          if (idx == bf_last) begin
            idx <= '0;
            stg <= (stg == ST_W'(PTS_LOG - 1)) ? '0 : stg + ST_W'(1);
          end else begin
            idx <= idx + PTS_LOG'(1);
          end
        end
        S_P_M1: begin
          bi   <= signed'(ws_rdata[DAT_W-1:0]);
          mold <= acc_vld[idx] ? mean_rdata : '0;
          sold <= acc_vld[idx] ? spr_rdata : '0;
        end
        S_P_M2: acc <= prod;
        S_P_M3: begin
          m_new <= m_sat;
          if (p_full >= 50'(m_sat))
            d <= 32'(p_full - 50'(m_sat));
          else
            d <= 32'(50'(m_sat) - p_full);
        end
        S_P_M5: begin
          acc_vld[idx] <= 1'b1;
          div_num <= SPR_W'(m_new);
          div_rem <= '0;
          sold    <= sp_new;
          it      <= '0;
        end
        S_DIV_M, S_DIV_S: begin
          if (it == 6'(DIV_STEPS - 1)) begin
            it      <= '0;
            div_rem <= '0;
            if (state == S_DIV_M) begin
              mq      <= MEAN_W'({div_num[SPR_W-2:0], dv_ge});
              div_num <= sold;
            end else begin
              sq_v    <= {div_num[SPR_W-2:0], dv_ge, 16'd0};
              sq_rem  <= '0;
              sq_root <= '0;
            end
          end else begin
            div_rem <= dv_ge ? dv_diff[FT_W-1:0] : dv_trial[FT_W-1:0];
            div_num <= {div_num[SPR_W-2:0], dv_ge};
            it      <= it + 6'd1;
          end
        end
        S_SQRT: begin
          sq_v    <= {sq_v[61:0], 2'b00};
          sq_rem  <= sr_ge ? sr_rem2 - sr_trial : sr_rem2;
          sq_root <= {sq_root[30:0], sr_ge};
          it      <= it + 6'd1;
        end
        S_OUT: begin
          if (!out_stall) begin
            idx <= idx + PTS_LOG'(1);
            if (idx == PTS_LOG'(PTS - 1)) begin
              if (FT_W'(frame_count) + FT_W'(1) >= divisor) begin
                frame_count <= '0;
                acc_vld     <= '0;
              end else begin
                frame_count <= frame_count + FI_W'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign bin_index     = BIN_W'(idx);
  assign frame_index   = frame_count;
  assign mean_power    = mq;
  assign spread        = sq_root;
  assign last_of_frame = (idx == PTS_LOG'(PTS - 1));

  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while results pending");
  a_hold_while_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(bin_index) && $stable(mean_power)
    && $stable(spread))) else $error("result beat changed while stalled");
  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_of_frame) |=> !in_stall)
    else $error("not idle after last bin");
  a_bin_advances: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_of_frame) |=> !out_valid)
    else $error("bin repeated");
endmodule

@@ dv/spectral_power_mean_spread_unit_tb.sv @@
// Testbench for spectral_power_mean_spread_unit: streams sample frames under random
// idling and stalls, predicts per-bin mean power and spread, checks every result beat.
// Depends on spms_pkg and the unit's RTL.
`timescale 1ns / 1ps
module spectral_power_mean_spread_unit_tb;
  import spms_pkg::*;

  localparam int LIMIT = 1000000;

  typedef struct {
    bit [5:0]  bin;
    bit [9:0]  fidx;
    bit [31:0] mean;
    bit [31:0] spr;
    bit        last;
  } bin_stats_t;

  class bin_stats_board;
    int qc[17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
                   20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
    bit [10:0]       frames_cfg = 11'd16;
    bit signed [15:0] frame[64];
    int              pos;
    int              fcount;
    bit [31:0]       mean_acc[64];
    bit [63:0]       spread_acc[64];
    bin_stats_t      pending[$];
    int              errors;

    function int tw_cos(int m);
      m = m & 31;
      return (m <= 16) ? qc[m] : -qc[32 - m];
    endfunction

    function int tw_sin(int m);
      m = m & 31;
      return (m <= 16) ? qc[16 - m] : qc[m - 16];
    endfunction

    function int rnd_q15(longint p);
      return int'((p + 64'sd16384) >>> 15);
    endfunction

    function bit [31:0] root(bit [63:0] v);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r[31:0];
    endfunction

    function void set_frames(bit [10:0] v);
      frames_cfg = v;
    endfunction

    function void note_sample(bit signed [15:0] s);
      int re[64], im[64];
      int div, half, stp, a, b, tr, ti, ar, ai, r;
      longint c, sn, br, bi;
      bit [63:0] pw, p, m, d, sq, sp;
      bin_stats_t e;
      frame[pos] = s;
      if (pos < 63) begin
        pos++;
        return;
      end
      pos = 0;
      div = (frames_cfg == 0) ? 1 : (frames_cfg > 1024) ? 1024 : frames_cfg;
      for (int i = 0; i < 64; i++) begin
        r = 0;
        for (int k = 0; k < 6; k++) r = (r << 1) | ((i >> k) & 1);
        re[i] = frame[r];
        im[i] = 0;
      end
      for (int len = 2; len <= 64; len = len << 1) begin
        half = len >> 1;
        stp = 64 / len;
        for (int base = 0; base < 64; base += len) begin
          for (int k = 0; k < half; k++) begin
            a = base + k;
            b = base + k + half;
            c = tw_cos(k * stp);
            sn = tw_sin(k * stp);
            br = re[b];
            bi = im[b];
            tr = rnd_q15(br * c + bi * sn);
            ti = rnd_q15(bi * c - br * sn);
            ar = re[a];
            ai = im[a];
            re[a] = ar + tr;
            im[a] = ai + ti;
            re[b] = ar - tr;
            im[b] = ai - ti;
          end
        end
      end
      for (int j = 0; j < 64; j++) begin
        pw = longint'(re[j]) * longint'(re[j]) + longint'(im[j]) * longint'(im[j]);
        p = pw >> 14;
        m = mean_acc[j] + p / 64;
        if (m > 64'hFFFF_FFFF) m = 64'hFFFF_FFFF;
        mean_acc[j] = m[31:0];
        d = (p >= m) ? p - m : m - p;
        sq = ((d * d) >> 16) / 64;
        sp = spread_acc[j] + sq;
        if (sp > 64'hFFFF_FFFF_FFFF || sp < sq) sp = 64'hFFFF_FFFF_FFFF;
        spread_acc[j] = sp;
        e.bin = 6'(j);
        e.fidx = 10'(fcount);
        e.mean = 32'(m / div);
        e.spr = root((sp / div) << 16);
        e.last = (j == 63);
        pending.insert(pending.size(), e);
      end
      fcount++;
      if (fcount >= div) begin
        fcount = 0;
        foreach (mean_acc[j]) begin
          mean_acc[j] = 0;
          spread_acc[j] = 0;
        end
      end
    endfunction

    function void check_beat(bin_stats_t got);
      bin_stats_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat, bin_index %0d", got.bin);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.bin != e.bin) begin
        $error("bin_index expected %0d actual %0d", e.bin, got.bin);
        errors++;
      end
      if (got.fidx != e.fidx) begin
        $error("frame_index expected %0d actual %0d", e.fidx, got.fidx);
        errors++;
      end
      if (got.mean != e.mean) begin
        $error("mean_power expected %0h actual %0h", e.mean, got.mean);
        errors++;
      end
      if (got.spr != e.spr) begin
        $error("spread expected %0h actual %0h", e.spr, got.spr);
        errors++;
      end
      if (got.last != e.last) begin
        $error("last_of_frame expected %0d actual %0d", e.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 cfg_wr_en = 0;
  logic [FT_W-1:0]      cfg_wr_data = '0;
  logic                 in_valid = 0;
  logic                 in_stall;
  logic signed [SMP_W-1:0] sample = '0;
  logic                 out_valid;
  logic                 out_stall = 0;
  logic [BIN_W-1:0]     bin_index;
  logic [FI_W-1:0]      frame_index;
  logic [MEAN_W-1:0]    mean_power;
  logic [31:0]          spread;
  logic                 last_of_frame;

  bin_stats_board board = new();
  int cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;

  spectral_power_mean_spread_unit i_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .bin_index(bin_index), .frame_index(frame_index), .mean_power(mean_power),
    .spread(spread), .last_of_frame(last_of_frame)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    bin_stats_t got;
    cycles++;
    if (cycles > LIMIT) begin
      $display("spectral_power_mean_spread_unit test failed");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      got.bin = bin_index;
      got.fidx = frame_index;
      got.mean = mean_power;
      got.spr = spread;
      got.last = last_of_frame;
      board.check_beat(got);
    end
    if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  task automatic send_sample(logic signed [15:0] v);
    int gap;
    in_valid <= 1'b1;
    sample <= v;
    do @(posedge clk); while (in_stall);
    board.note_sample(v);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_frames(logic [10:0] v);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_frames(v);
  endtask

  function automatic logic signed [15:0] pick_sample(int kind, int i);
    logic signed [15:0] dir[20] = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1,
      16'sh5555, 16'shAAAA, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd0,
      16'sh7FFF, 16'sh8000, 16'sh00FF, 16'shFF00, 16'sh0F0F, 16'shF0F0, 16'sd2, -16'sd2};
    case (kind)
      0: return (i < 20) ? dir[i] : 16'($urandom);
      1: return 16'($urandom);
      2: return (i < 32) ? 16'sd32767 : -16'sd32768;
      3: return 16'($signed($urandom_range(0, 512)) - 256);
      default: return (i[0] ? 16'sd32767 : -16'sd32767) + 16'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic run_frames(int n, int kind);
    for (int f = 0; f < n; f++)
      for (int i = 0; i < 64; i++) send_sample(pick_sample(kind + f, i));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_frames(1, 0);
    write_frames(11'd2047);
    run_frames(1, 1);
    write_frames(11'd0);
    run_frames(1, 2);
    write_frames(11'd3);
    run_frames(1, 3);
    write_frames(11'd1024);
    run_frames(1, 4);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0) begin
      $display("spectral_power_mean_spread_unit test passed");
    end else begin
      $display("spectral_power_mean_spread_unit test failed");
    end
    $finish;
  end
endmodule

@@ spectral_power_mean_spread_unit.f @@
sv/spms_pkg.sv
sv/spms_ram.sv
sv/spectral_power_mean_spread_unit.sv
dv/spectral_power_mean_spread_unit_tb.sv
